// File: rtl/cbq_pkg.sv
// shared types and constants of the cascaded biquad filter
package cbq_pkg;

   localparam int SAMPLE_W = 16;
   localparam int COEF_W   = 32;
   localparam int ACC_W    = 48;
   localparam int OPER_W   = 25;
   localparam int PROD_W   = COEF_W + OPER_W;

   localparam int SAMPLE_MAX = 32767;
   localparam int SAMPLE_MIN = -32768;

   // configuration register indexes
   localparam int REG_INDEX_W = 3;
   localparam logic [REG_INDEX_W-1:0] REG_COEF_B0 = 3'd0;
   localparam logic [REG_INDEX_W-1:0] REG_COEF_B1 = 3'd1;
   localparam logic [REG_INDEX_W-1:0] REG_COEF_B2 = 3'd2;
   localparam logic [REG_INDEX_W-1:0] REG_COEF_A1 = 3'd3;
   localparam logic [REG_INDEX_W-1:0] REG_COEF_A2 = 3'd4;
   localparam logic [REG_INDEX_W-1:0] REG_SECTIONS = 3'd5;

   localparam logic signed [COEF_W-1:0] COEF_B0_RESET = 32'sd268435456;
   localparam logic [1:0] SECTIONS_RESET = 2'd3;

   typedef struct packed {
      logic signed [COEF_W-1:0] b0;
      logic signed [COEF_W-1:0] b1;
      logic signed [COEF_W-1:0] b2;
      logic signed [COEF_W-1:0] a1;
      logic signed [COEF_W-1:0] a2;
   } coef_set_type;

   typedef struct packed {
      logic                       valid;
      logic signed [SAMPLE_W-1:0] sample;
   } beat_type;

endpackage

// File: rtl/cbq_section_cell.sv
// one direct form I biquad section with its own history and one shared multiplier
module cbq_section_cell #(
   parameter int COEF_FRAC_BITS = 28,
   parameter int OUT_FRAC_BITS  = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  cbq_pkg::coef_set_type coef,
   input  logic                  enable,
   input  cbq_pkg::beat_type     beat_in,
   output cbq_pkg::beat_type     beat_out
);

   localparam int SW = cbq_pkg::SAMPLE_W;
   localparam int AW = cbq_pkg::ACC_W;
   localparam int PW = cbq_pkg::PROD_W;
   localparam int OW = cbq_pkg::OPER_W;
   localparam int FW = PW + 24;
   localparam int TW = AW + 1;
   localparam int FF_RSH = (COEF_FRAC_BITS >= OUT_FRAC_BITS) ? COEF_FRAC_BITS - OUT_FRAC_BITS : 0;
   localparam int FF_LSH = (COEF_FRAC_BITS >= OUT_FRAC_BITS) ? 0 : OUT_FRAC_BITS - COEF_FRAC_BITS;

   localparam logic [3:0] STEP_B0     = 4'd0;
   localparam logic [3:0] STEP_B1     = 4'd1;
   localparam logic [3:0] STEP_B2     = 4'd2;
   localparam logic [3:0] STEP_A1_LO  = 4'd3;
   localparam logic [3:0] STEP_A1_HI  = 4'd4;
   localparam logic [3:0] STEP_A2_LO  = 4'd5;
   localparam logic [3:0] STEP_A2_HI  = 4'd6;
   localparam logic [3:0] STEP_FINISH = 4'd8;

   localparam logic [TW-1:0] RND = (TW'(1) << OUT_FRAC_BITS) - TW'(1);
   localparam logic signed [TW-1:0] HI_LIM = TW'(cbq_pkg::SAMPLE_MAX);
   localparam logic signed [TW-1:0] LO_LIM = TW'(cbq_pkg::SAMPLE_MIN);

   logic                 run_ff, run_in;
   logic [3:0]           step_ff, step_in;
   logic [3:0]           kind_ff;
   logic                 acc_en_ff, acc_en_in;
   logic signed [SW-1:0] x_ff, x_in;
   logic signed [SW-1:0] x1_ff, x1_in, x2_ff, x2_in;
   logic signed [AW-1:0] y1_ff, y1_in, y2_ff, y2_in;
   logic signed [AW-1:0] acc_ff, acc_in;
   logic signed [PW-1:0] prod_ff, prod_in;
   logic signed [PW-1:0] lo_ff, lo_in;
   cbq_pkg::beat_type    beat_out_ff, beat_out_in;

   logic signed [cbq_pkg::COEF_W-1:0] mul_coef;
   logic signed [OW-1:0]              mul_oper;
   logic signed [63:0]                ff_wide;
   logic signed [63:0]                ff_aligned;
   logic signed [FW-1:0]              fb_full;
   logic signed [FW-1:0]              fb_shift;
   logic signed [TW-1:0]              t_sum;
   logic signed [TW-1:0]              t_trunc;
   logic signed [SW-1:0]              sat;

   // operand select for the one multiplier
   always_comb begin
      unique case (step_ff)
         STEP_B0: begin
            mul_coef = coef.b0;
            mul_oper = OW'(x_ff);
         end
         STEP_B1: begin
            mul_coef = coef.b1;
            mul_oper = OW'(x1_ff);
         end
         STEP_B2: begin
            mul_coef = coef.b2;
            mul_oper = OW'(x2_ff);
         end
         STEP_A1_LO: begin
            mul_coef = coef.a1;
            mul_oper = {1'b0, y1_ff[23:0]};
         end
         STEP_A1_HI: begin
            mul_coef = coef.a1;
            mul_oper = {y1_ff[AW-1], y1_ff[AW-1:24]};
         end
         STEP_A2_LO: begin
            mul_coef = coef.a2;
            mul_oper = {1'b0, y2_ff[23:0]};
         end
         STEP_A2_HI: begin
            mul_coef = coef.a2;
            mul_oper = {y2_ff[AW-1], y2_ff[AW-1:24]};
         end
         default: begin
            mul_coef = '0;
            mul_oper = '0;
         end
      endcase
   end

   assign prod_in = mul_coef * mul_oper;

   // feedforward term aligned to the output fraction
   assign ff_wide    = {{(64-PW){prod_ff[PW-1]}}, prod_ff};
   assign ff_aligned = (ff_wide >>> FF_RSH) <<< FF_LSH;

   // exact feedback product from its two halves, then floored
   assign fb_full  = $signed({prod_ff, 24'b0}) + $signed({{24{lo_ff[PW-1]}}, lo_ff});
   assign fb_shift = fb_full >>> COEF_FRAC_BITS;

   // truncate toward zero, then clamp to int16
   assign t_sum   = $signed({acc_ff[AW-1], acc_ff}) + $signed(acc_ff[AW-1] ? RND : '0);
   assign t_trunc = t_sum >>> OUT_FRAC_BITS;

   always_comb begin
      priority if (t_trunc > HI_LIM) begin
         sat = SW'(cbq_pkg::SAMPLE_MAX);
      end else if (t_trunc < LO_LIM) begin
         sat = SW'(cbq_pkg::SAMPLE_MIN);
      end else begin
         sat = t_trunc[SW-1:0];
      end
   end

   always_comb begin
      run_in      = run_ff;
      step_in     = step_ff;
      x_in        = x_ff;
      x1_in       = x1_ff;
      x2_in       = x2_ff;
      y1_in       = y1_ff;
      y2_in       = y2_ff;
      acc_in      = acc_ff;
      lo_in       = lo_ff;
      beat_out_in = '{valid: 1'b0, sample: beat_out_ff.sample};
      acc_en_in   = run_ff && (step_ff <= STEP_A2_HI);

      if (acc_en_ff) begin
         unique case (kind_ff)
            STEP_B0, STEP_B1, STEP_B2: acc_in = acc_ff + ff_aligned[AW-1:0];
            STEP_A1_LO, STEP_A2_LO:    lo_in  = prod_ff;
            STEP_A1_HI, STEP_A2_HI:    acc_in = acc_ff - fb_shift[AW-1:0];
            default:                   acc_in = acc_ff;
         endcase
      end

      if (!run_ff) begin
         if (beat_in.valid && enable) begin
            run_in  = 1'b1;
            step_in = STEP_B0;
            x_in    = beat_in.sample;
            acc_in  = '0;
         end
      end else if (step_ff == STEP_FINISH) begin
         run_in      = 1'b0;
         step_in     = STEP_B0;
         x2_in       = x1_ff;
         x1_in       = x_ff;
         y2_in       = y1_ff;
         y1_in       = acc_ff;
         beat_out_in = '{valid: 1'b1, sample: sat};
      end else begin
         step_in = step_ff + 4'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff      <= 1'b0;
         step_ff     <= STEP_B0;
         acc_en_ff   <= 1'b0;
         x1_ff       <= '0;
         x2_ff       <= '0;
         y1_ff       <= '0;
         y2_ff       <= '0;
         beat_out_ff <= '0;
      end else begin
         run_ff      <= run_in;
         step_ff     <= step_in;
         acc_en_ff   <= acc_en_in;
         x1_ff       <= x1_in;
         x2_ff       <= x2_in;
         y1_ff       <= y1_in;
         y2_ff       <= y2_in;
         beat_out_ff <= beat_out_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff <= step_ff;
      prod_ff <= prod_in;
      lo_ff   <= lo_in;
      x_ff    <= x_in;
      acc_ff  <= acc_in;
   end

   assign beat_out = beat_out_ff;

   a_finish_only_when_running: assert property (@(posedge clock) disable iff (reset)
      beat_out_in.valid |-> run_ff)
      else $error("section result without a running sequence");

   a_no_start_while_running: assert property (@(posedge clock) disable iff (reset)
      run_ff && (step_ff != STEP_FINISH) |=> run_ff)
      else $error("section sequence stopped early");

   a_step_in_range: assert property (@(posedge clock) disable iff (reset)
      run_ff |-> (step_ff <= STEP_FINISH))
      else $error("section step counter out of range");

endmodule

// File: rtl/cascaded_biquad_filter_unit.sv
// top level: configuration registers, chain of biquad section cells, output register
//
//  channel  | handshake            | payload
//  ---------+----------------------+----------------------
//  req      | req_valid/req_stall  | req_sample_in  (s16)
//  rsp      | rsp_valid/rsp_stall  | rsp_sample_out (s16)
//  csr      | csr_write_enable     | csr_index, csr_write_data
//
// in each active section one 32x25 multiplier per cell runs seven
// products one after the other, then the section result moves to the next cell.
// synchronous reset clears coefficients to pass-through and all section history.
// a new item is taken once the previous result sits in the output register, also
// while that result is stalled; a result that finds the output stalled waits in a
// holding register and keeps req_stall high.
module cascaded_biquad_filter_unit #(
   parameter int MAX_SECTIONS   = 3,
   parameter int COEF_FRAC_BITS = 28,
   parameter int OUT_FRAC_BITS  = 16
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  logic signed [cbq_pkg::SAMPLE_W-1:0]    req_sample_in,
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output logic signed [cbq_pkg::SAMPLE_W-1:0]    rsp_sample_out,
   input  logic                                   csr_write_enable,
   input  logic [cbq_pkg::REG_INDEX_W-1:0]        csr_index,
   input  logic [cbq_pkg::COEF_W-1:0]             csr_write_data
);

   localparam int SW = cbq_pkg::SAMPLE_W;

   cbq_pkg::coef_set_type coef_ff;
   logic [1:0]            sections_ff;
   logic [1:0]            n_eff;
   logic                  busy_ff, busy_in;
   cbq_pkg::beat_type     start_ff;
   logic                  accept;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic signed [SW-1:0]  rsp_data_ff, rsp_data_in;
   logic                  pend_valid_ff, pend_valid_in;
   logic signed [SW-1:0]  pend_data_ff, pend_data_in;
   logic                  rsp_free;
   cbq_pkg::beat_type     final_beat;
   logic [MAX_SECTIONS-1:0] active;
   logic [MAX_SECTIONS-1:0] done_vec;
   cbq_pkg::beat_type     cell_in  [MAX_SECTIONS];
   cbq_pkg::beat_type     cell_out [MAX_SECTIONS];

   assign accept    = req_valid && !req_stall;
   assign req_stall = busy_ff;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         coef_ff     <= '{b0: cbq_pkg::COEF_B0_RESET, b1: '0, b2: '0, a1: '0, a2: '0};
         sections_ff <= cbq_pkg::SECTIONS_RESET;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            cbq_pkg::REG_COEF_B0:  coef_ff.b0  <= csr_write_data;
            cbq_pkg::REG_COEF_B1:  coef_ff.b1  <= csr_write_data;
            cbq_pkg::REG_COEF_B2:  coef_ff.b2  <= csr_write_data;
            cbq_pkg::REG_COEF_A1:  coef_ff.a1  <= csr_write_data;
            cbq_pkg::REG_COEF_A2:  coef_ff.a2  <= csr_write_data;
            cbq_pkg::REG_SECTIONS: sections_ff <= csr_write_data[1:0];
            default: ;
         endcase
      end
   end

   // zero sections acts as one, too many as all
   always_comb begin
      n_eff = (sections_ff == 2'd0) ? 2'd1 : sections_ff;
      if (int'(n_eff) > MAX_SECTIONS) begin
         n_eff = 2'(MAX_SECTIONS);
      end
   end

   always_comb begin
      final_beat = '{valid: 1'b0, sample: cell_out[0].sample};
      for (int i = 0; i < MAX_SECTIONS; i++) begin
         active[i]   = (i < int'(n_eff));
         done_vec[i] = cell_out[i].valid;
         if (cell_out[i].valid && (i == int'(n_eff) - 1)) begin
            final_beat = cell_out[i];
         end
      end
   end

   generate
      for (genvar g = 0; g < MAX_SECTIONS; g++) begin : g_cell
         if (g == 0) begin : g_first
            assign cell_in[g] = start_ff;
         end else begin : g_next
            assign cell_in[g] = cell_out[g-1];
         end
         cbq_section_cell #(
            .COEF_FRAC_BITS (COEF_FRAC_BITS),
            .OUT_FRAC_BITS  (OUT_FRAC_BITS)
         ) u_cell (
            .clock    (clock),
            .reset    (reset),
            .coef     (coef_ff),
            .enable   (active[g]),
            .beat_in  (cell_in[g]),
            .beat_out (cell_out[g])
         );
      end
   endgenerate

   // output register with one holding slot behind it
   assign rsp_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      busy_in       = busy_ff || accept;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_data_in   = rsp_data_ff;
      pend_valid_in = pend_valid_ff;
      pend_data_in  = pend_data_ff;
      priority if (pend_valid_ff && rsp_free) begin
         rsp_valid_in  = 1'b1;
         rsp_data_in   = pend_data_ff;
         pend_valid_in = 1'b0;
         busy_in       = 1'b0;
      end else if (final_beat.valid && rsp_free) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = final_beat.sample;
         busy_in      = 1'b0;
      end else if (final_beat.valid) begin
         pend_valid_in = 1'b1;
         pend_data_in  = final_beat.sample;
      end else begin
         pend_valid_in = pend_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff       <= 1'b0;
         start_ff      <= '0;
         rsp_valid_ff  <= 1'b0;
         pend_valid_ff <= 1'b0;
      end else begin
         busy_ff       <= busy_in;
         start_ff      <= '{valid: accept, sample: req_sample_in};
         rsp_valid_ff  <= rsp_valid_in;
         pend_valid_ff <= pend_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff  <= rsp_data_in;
      pend_data_ff <= pend_data_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_sample_out = rsp_data_ff;

   a_pend_behind_output: assert property (@(posedge clock) disable iff (reset)
      pend_valid_ff |-> (rsp_valid_ff && busy_ff))
      else $error("holding slot used while output register empty");

   a_result_needs_item: assert property (@(posedge clock) disable iff (reset)
      final_beat.valid |-> (busy_ff && !pend_valid_ff))
      else $error("filter result with no item in flight");

   a_one_cell_done: assert property (@(posedge clock) disable iff (reset)
      $onehot0(done_vec))
      else $error("two sections finished in one cycle");

   a_accept_sets_busy: assert property (@(posedge clock) disable iff (reset)
      accept |=> busy_ff)
      else $error("accepted beat did not mark the unit busy");

endmodule
